FILE: rtl/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

    // Command codes.
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

    // Configuration register map.
    localparam int          CAP_W        = 7;
    localparam logic        REG_CAPACITY = 1'b0;
    localparam logic [6:0]  CAP_RESET    = 7'd64;

    localparam logic signed [31:0] PEEK_REFUSED = -32'sd1;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } cdq_cmd_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] data;
        logic               is_empty;
        logic               is_full;
    } cdq_rsp_t;

    // Control from the register block to the core.
    typedef struct packed {
        logic             clear;
        logic [CAP_W-1:0] eff_cap;
    } cdq_cfg_ctl_t;

endpackage

FILE: rtl/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // The read register holds its value until the next read.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/cdq_cfg.sv
`timescale 1ns / 1ps

module cdq_cfg
    import cdq_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output cdq_cfg_ctl_t ctl
);

    localparam int MAX_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (MAX_W > CAP_W) ? MAX_W : CAP_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

    logic [CAP_W-1:0] cap_reg;
    logic             wr_cap;

    assign pready = 1'b1;
    assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (wr_cap)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = 32'(cap_reg);
        end
    end

    // Out-of-range capacities saturate into 1..MAX_ENTRIES.
    always_comb
    begin
        ctl.clear = wr_cap;
        if (cap_reg == '0)
        begin
            ctl.eff_cap = CAP_W'(1);
        end
        else if (CMP_W'(cap_reg) > MAX_CMP)
        begin
            ctl.eff_cap = MAX_CMP[CAP_W-1:0];
        end
        else
        begin
            ctl.eff_cap = cap_reg;
        end
    end

endmodule

FILE: rtl/circular_deque_core.sv
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words in a ring of MAX_ENTRIES slots
// held in a single synchronous RAM. Head, tail and occupancy live in
// registers, so one command is accepted every cycle unless rsp_stall holds
// back a full pipeline; its response passes through stage 1 (the RAM read)
// and then the output register. Writing the capacity register over the APB
// port empties the deque; write it only while no transaction is in flight.
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cdq_cmd_t    cmd,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output cdq_rsp_t    rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    cdq_cfg_ctl_t cfg_ctl;

    cdq_cfg #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .ctl    (cfg_ctl)
    );

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    // Stage 1: command issued to the RAM, response waiting for read data.
    logic s1_valid_reg;
    logic s1_ok_reg, s1_ok_next;
    logic s1_peek_reg, s1_peek_next;
    logic s1_neg_reg, s1_neg_next;
    logic s1_empty_reg, s1_empty_next;
    logic s1_full_reg, s1_full_next;

    logic     rsp_valid_reg;
    cdq_rsp_t rsp_reg;

    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [31:0]      ram_rd_data;

    logic             s1_advance;
    logic             cmd_accept;
    logic [CMP_W-1:0] cap_cmp;
    logic             is_full_now;
    logic             is_empty_now;

    cdq_ram #(
        .WIDTH(32),
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(cmd.value),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign s1_advance = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall  = s1_valid_reg && !s1_advance;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign cap_cmp      = CMP_W'(cfg_ctl.eff_cap);
    assign is_full_now  = CMP_W'(occ_reg) >= cap_cmp;
    assign is_empty_now = (occ_reg == '0);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        s1_ok_next   = 1'b0;
        s1_peek_next = 1'b0;
        s1_neg_next  = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = tail_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = head_reg;

        if (cmd_accept)
        begin
            case (cmd.command)
                CMD_PUSH_FRONT:
                begin
                    if (!is_full_now)
                    begin
                        head_next   = slot_prev(head_reg);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = slot_prev(head_reg);
                        occ_next    = occ_reg + OCC_W'(1);
                        s1_ok_next  = 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (!is_full_now)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tail_reg;
                        tail_next   = slot_next(tail_reg);
                        occ_next    = occ_reg + OCC_W'(1);
                        s1_ok_next  = 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (!is_empty_now)
                    begin
                        head_next  = slot_next(head_reg);
                        occ_next   = occ_reg - OCC_W'(1);
                        s1_ok_next = 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (!is_empty_now)
                    begin
                        tail_next  = slot_prev(tail_reg);
                        occ_next   = occ_reg - OCC_W'(1);
                        s1_ok_next = 1'b1;
                    end
                end
                CMD_PEEK_FRONT:
                begin
                    if (!is_empty_now)
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = head_reg;
                        s1_peek_next = 1'b1;
                        s1_ok_next   = 1'b1;
                    end
                    else
                    begin
                        s1_neg_next = 1'b1;
                    end
                end
                CMD_PEEK_BACK:
                begin
                    if (!is_empty_now)
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = slot_prev(tail_reg);
                        s1_peek_next = 1'b1;
                        s1_ok_next   = 1'b1;
                    end
                    else
                    begin
                        s1_neg_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        s1_empty_next = (occ_next == '0);
        s1_full_next  = CMP_W'(occ_next) >= cap_cmp;

        // A capacity write empties the deque; the user must issue it only while idle (not enforced here).
        if (cfg_ctl.clear)
        begin
            head_next = '0;
            tail_next = '0;
            occ_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;

            if (cmd_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_peek_reg  <= s1_peek_next;
            s1_neg_reg   <= s1_neg_next;
            s1_empty_reg <= s1_empty_next;
            s1_full_reg  <= s1_full_next;
        end

        // The RAM read register holds while stage 1 waits, so its data is
        // still valid whenever stage 1 moves into the output register.
        if (s1_advance && s1_valid_reg)
        begin
            rsp_reg.accepted <= s1_ok_reg;
            rsp_reg.is_empty <= s1_empty_reg;
            rsp_reg.is_full  <= s1_full_reg;
            if (s1_peek_reg)
            begin
                rsp_reg.data <= ram_rd_data;
            end
            else if (s1_neg_reg)
            begin
                rsp_reg.data <= PEEK_REFUSED;
            end
            else
            begin
                rsp_reg.data <= '0;
            end
        end
    end

endmodule
